>>> src/tqi_pkg.sv
package tqi_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int STAMP_W  = 32;
    localparam int ANGLE_W  = 32;
    localparam int DIFF_W   = STAMP_W + 1;
    localparam int WIDE_W   = 64;
    localparam int PROD_W   = WIDE_W + DIFF_W;
    localparam int NUM_W    = PROD_W + 1;
    localparam int MIN_SAMPLES = 3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FEW   = 2'd1;
    localparam logic [1:0] STATUS_OLD   = 2'd2;
    localparam logic [1:0] STATUS_EQUAL = 2'd3;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_INSERT    = 4'd1;
    localparam logic [3:0] OP_QUERY     = 4'd2;
    localparam logic [3:0] OP_SRCH_RD   = 4'd3;
    localparam logic [3:0] OP_SRCH_NEXT = 4'd4;
    localparam logic [3:0] OP_CENTRE    = 4'd5;
    localparam logic [3:0] OP_RD_N      = 4'd6;
    localparam logic [3:0] OP_RD_M      = 4'd7;
    localparam logic [3:0] OP_RD_O      = 4'd8;
    localparam logic [3:0] OP_CAP_O     = 4'd9;
    localparam logic [3:0] OP_MUL       = 4'd10;
    localparam logic [3:0] OP_DIV       = 4'd11;
    localparam logic [3:0] OP_LOAD_OUT  = 4'd12;

    // Neville sequence steps
    localparam logic [3:0] NV_NM_MUL0  = 4'd0;
    localparam logic [3:0] NV_NM_MUL1  = 4'd1;
    localparam logic [3:0] NV_NM_DIV   = 4'd2;
    localparam logic [3:0] NV_MO_MUL0  = 4'd3;
    localparam logic [3:0] NV_MO_MUL1  = 4'd4;
    localparam logic [3:0] NV_MO_DIV   = 4'd5;
    localparam logic [3:0] NV_FIN_MUL0 = 4'd6;
    localparam logic [3:0] NV_FIN_MUL1 = 4'd7;
    localparam logic [3:0] NV_FIN_DIV  = 4'd8;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] step;
        logic [1:0] status;
    } tqi_cmd_t;

    typedef struct packed {
        logic under3;
        logic hit;
        logic k_last;
        logic eq_stamps;
        logic mul_done;
        logic div_done;
    } tqi_stat_t;

endpackage

>>> src/tqi_if.sv
interface tqi_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] stamp;
    logic signed [31:0] sample_angle;

    modport source (output valid, output cmd, output stamp, output sample_angle, input ready);
    modport sink   (input valid, input cmd, input stamp, input sample_angle, output ready);
endinterface

interface tqi_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_angle;
    logic [31:0] out_stamp;
    logic [1:0]  status;

    modport source (output valid, output out_angle, output out_stamp, output status, input ready);
    modport sink   (input valid, input out_angle, input out_stamp, input status, output ready);
endinterface

>>> src/timestamped_quadratic_interpolator.sv
// Time-stamped quadratic interpolator.
// in_ch carries transactions: cmd 0 stores (stamp, sample_angle) in a ring
// of DEPTH samples, overwriting the oldest; cmd 1 asks for the angle at
// time stamp. Only a query gives an out_ch transaction: out_angle (Q16.16,
// saturated, zero on error), out_stamp (echo) and status.
// An insert is written into the ring while idle. A query searches the
// history entry by entry, fetches the three points, checks the stamps,
// then runs six shift-add multiplies and three restoring divides on one
// shared multiplier and one shared divider. Early-exit statuses (too few
// samples, too old, equal stamps) skip the multiplies and divides.
// One query is worked on at a time.
// A finished result is held in the output register; the next transaction
// is taken while it waits, but a further query result stalls until out_ch
// is ready. Reset empties the history and drops any pending result; the
// history store itself is not cleared.
module timestamped_quadratic_interpolator
    import tqi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    tqi_in_if.sink    in_ch,
    tqi_out_if.source out_ch
);

    tqi_cmd_t  cmd;
    tqi_stat_t stat;

    tqi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tqi_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_stamp   (in_ch.stamp),
        .in_angle   (in_ch.sample_angle),
        .out_angle  (out_ch.out_angle),
        .out_stamp  (out_ch.out_stamp),
        .out_status (out_ch.status)
    );

endmodule

>>> src/tqi_ctrl.sv
module tqi_ctrl
    import tqi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_cmd,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  tqi_stat_t stat,
    output tqi_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCMP  = 4'd3;
    localparam logic [3:0] S_RDN   = 4'd4;
    localparam logic [3:0] S_RDM   = 4'd5;
    localparam logic [3:0] S_RDO   = 4'd6;
    localparam logic [3:0] S_CAPO  = 4'd7;
    localparam logic [3:0] S_EQ    = 4'd8;
    localparam logic [3:0] S_ISSUE = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] status_reg, status_next;
    logic       out_valid_reg, out_valid_next;
    logic       step_is_div;

    assign step_is_div = (step_reg == NV_NM_DIV) || (step_reg == NV_MO_DIV)
                      || (step_reg == NV_FIN_DIV);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.step       = step_reg;
        cmd.status     = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd)
                    begin
                        cmd.op     = OP_QUERY;
                        state_next = S_CHK;
                    end
                    else
                    begin
                        cmd.op = OP_INSERT;
                    end
                end
            end
            S_CHK:
            begin
                if (stat.under3)
                begin
                    status_next = STATUS_FEW;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                cmd.op     = OP_SRCH_RD;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (stat.hit)
                begin
                    cmd.op     = OP_CENTRE;
                    state_next = S_RDN;
                end
                else if (stat.k_last)
                begin
                    status_next = STATUS_OLD;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_SRCH_NEXT;
                    state_next = S_SRD;
                end
            end
            S_RDN:
            begin
                cmd.op     = OP_RD_N;
                state_next = S_RDM;
            end
            S_RDM:
            begin
                cmd.op     = OP_RD_M;
                state_next = S_RDO;
            end
            S_RDO:
            begin
                cmd.op     = OP_RD_O;
                state_next = S_CAPO;
            end
            S_CAPO:
            begin
                cmd.op     = OP_CAP_O;
                state_next = S_EQ;
            end
            S_EQ:
            begin
                if (stat.eq_stamps)
                begin
                    status_next = STATUS_EQUAL;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = STATUS_OK;
                    step_next   = NV_NM_MUL0;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.op     = step_is_div ? OP_DIV : OP_MUL;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.mul_done || stat.div_done)
                begin
                    if (step_reg == NV_FIN_DIV)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        step_next  = step_reg + 4'd1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= NV_NM_MUL0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/tqi_dp.sv
module tqi_dp
    import tqi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tqi_cmd_t                  cmd,
    output tqi_stat_t                 stat,
    input  logic [STAMP_W-1:0]        in_stamp,
    input  logic signed [ANGLE_W-1:0] in_angle,
    output logic signed [ANGLE_W-1:0] out_angle,
    output logic [STAMP_W-1:0]        out_stamp,
    output logic [1:0]                out_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MCW = $clog2(DIFF_W + 1);
    localparam int DCW = $clog2(NUM_W + 1);

    logic [STAMP_W-1:0] stamp_mem [DEPTH];
    logic [ANGLE_W-1:0] angle_mem [DEPTH];

    logic [AW-1:0] newest_reg, newest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, c_reg;
    logic [AW-1:0] rd_age, rd_slot, wr_slot;
    logic [AW:0]   slot_sum;
    logic [STAMP_W-1:0] rd_stamp_reg;
    logic [ANGLE_W-1:0] rd_angle_reg;

    logic [STAMP_W-1:0] t_reg, tn_reg, tm_reg, to_reg;
    logic signed [ANGLE_W-1:0] an_reg, am_reg, ao_reg;
    logic signed [WIDE_W-1:0]  pnm_reg, pmo_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;
    logic [STAMP_W-1:0]        out_stamp_reg;
    logic [1:0]                out_status_reg;

    logic signed [DIFF_W-1:0] dn, dm, d_o;

    // shift-add multiplier
    logic [WIDE_W-1:0]  ma_reg;
    logic [DIFF_W-1:0]  mb_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               mneg_reg, msub_reg, mbusy_reg;
    logic [MCW-1:0]     mcnt_reg;
    logic signed [WIDE_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic               mul_sub;
    logic signed [NUM_W-1:0]  sprod;

    // restoring divider
    logic [NUM_W-1:0]   dq_reg;
    logic [DIFF_W-1:0]  drem_reg;
    logic [DIFF_W-1:0]  dden_reg;
    logic               dneg_reg, dsat32_reg, dbusy_reg;
    logic [1:0]         ddest_reg;
    logic [DCW-1:0]     dcnt_reg;
    logic signed [DIFF_W-1:0] div_den;
    logic [DIFF_W:0]    dtrial;
    logic               dfits;
    logic [NUM_W-1:0]   dlim;
    logic [WIDE_W-1:0]  dclamp;
    logic [WIDE_W-1:0]  dres;
    logic [NUM_W-1:0]   num_mag;

    logic k_last;

    assign k_last = (k_reg == count_reg - CW'(1));

    always_comb
    begin
        unique case (cmd.op)
            OP_RD_N:  rd_age = AW'(c_reg - CW'(1));
            OP_RD_M:  rd_age = AW'(c_reg);
            OP_RD_O:  rd_age = AW'(c_reg + CW'(1));
            default:  rd_age = AW'(k_reg);
        endcase
        slot_sum = {1'b0, newest_reg} + (AW+1)'(DEPTH) - {1'b0, rd_age};
        if (slot_sum >= (AW+1)'(DEPTH))
        begin
            slot_sum = slot_sum - (AW+1)'(DEPTH);
        end
        rd_slot = slot_sum[AW-1:0];
        wr_slot = (newest_reg == AW'(DEPTH - 1)) ? '0 : newest_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_INSERT)
        begin
            stamp_mem[wr_slot] <= in_stamp;
            angle_mem[wr_slot] <= in_angle;
        end
        rd_stamp_reg <= stamp_mem[rd_slot];
        rd_angle_reg <= angle_mem[rd_slot];
    end

    always_comb
    begin
        newest_next = newest_reg;
        count_next  = count_reg;
        if (cmd.op == OP_INSERT)
        begin
            newest_next = wr_slot;
            if (count_reg != CW'(DEPTH))
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    assign dn  = DIFF_W'({1'b0, t_reg}) - DIFF_W'({1'b0, tn_reg});
    assign dm  = DIFF_W'({1'b0, t_reg}) - DIFF_W'({1'b0, tm_reg});
    assign d_o = DIFF_W'({1'b0, t_reg}) - DIFF_W'({1'b0, to_reg});

    always_comb
    begin
        mul_a   = WIDE_W'(an_reg);
        mul_b   = dm;
        mul_sub = 1'b0;
        div_den = DIFF_W'({1'b0, tn_reg}) - DIFF_W'({1'b0, tm_reg});
        unique case (cmd.step)
            NV_NM_MUL0:
            begin
                mul_a = WIDE_W'(an_reg);
                mul_b = dm;
            end
            NV_NM_MUL1:
            begin
                mul_a   = WIDE_W'(am_reg);
                mul_b   = dn;
                mul_sub = 1'b1;
            end
            NV_MO_MUL0:
            begin
                mul_a = WIDE_W'(am_reg);
                mul_b = d_o;
            end
            NV_MO_MUL1:
            begin
                mul_a   = WIDE_W'(ao_reg);
                mul_b   = dm;
                mul_sub = 1'b1;
            end
            NV_FIN_MUL0:
            begin
                mul_a = pnm_reg;
                mul_b = d_o;
            end
            NV_FIN_MUL1:
            begin
                mul_a   = pmo_reg;
                mul_b   = dn;
                mul_sub = 1'b1;
            end
            NV_MO_DIV:
            begin
                div_den = DIFF_W'({1'b0, tm_reg}) - DIFF_W'({1'b0, to_reg});
            end
            NV_FIN_DIV:
            begin
                div_den = DIFF_W'({1'b0, tn_reg}) - DIFF_W'({1'b0, to_reg});
            end
            default:
            begin
                div_den = DIFF_W'({1'b0, tn_reg}) - DIFF_W'({1'b0, tm_reg});
            end
        endcase
    end

    assign sprod   = mneg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
    assign num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    assign dtrial = {drem_reg, dq_reg[NUM_W-1]} - {1'b0, dden_reg};
    assign dfits  = !dtrial[DIFF_W];

    always_comb
    begin
        dlim = dsat32_reg ? (NUM_W'(1) << (ANGLE_W - 1)) : (NUM_W'(1) << (WIDE_W - 1));
        if (dneg_reg)
        begin
            dclamp = (dq_reg > dlim) ? WIDE_W'(dlim) : WIDE_W'(dq_reg);
            dres   = -dclamp;
        end
        else
        begin
            dclamp = (dq_reg >= dlim) ? WIDE_W'(dlim - NUM_W'(1)) : WIDE_W'(dq_reg);
            dres   = dclamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= '0;
            count_reg  <= '0;
            mbusy_reg  <= 1'b0;
            dbusy_reg  <= 1'b0;
        end
        else
        begin
            newest_reg <= newest_next;
            count_reg  <= count_next;
            if (cmd.op == OP_MUL)
            begin
                mbusy_reg <= 1'b1;
            end
            else if (mbusy_reg && (mcnt_reg == '0))
            begin
                mbusy_reg <= 1'b0;
            end
            if (cmd.op == OP_DIV)
            begin
                dbusy_reg <= 1'b1;
            end
            else if (dbusy_reg && (dcnt_reg == '0))
            begin
                dbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_QUERY:
            begin
                t_reg <= in_stamp;
                k_reg <= '0;
            end
            OP_SRCH_NEXT:
            begin
                k_reg <= k_reg + CW'(1);
            end
            OP_CENTRE:
            begin
                if (k_reg == '0)
                begin
                    c_reg <= CW'(1);
                end
                else if (k_last)
                begin
                    c_reg <= k_reg - CW'(1);
                end
                else
                begin
                    c_reg <= k_reg;
                end
            end
            OP_RD_M:
            begin
                tn_reg <= rd_stamp_reg;
                an_reg <= rd_angle_reg;
            end
            OP_RD_O:
            begin
                tm_reg <= rd_stamp_reg;
                am_reg <= rd_angle_reg;
            end
            OP_CAP_O:
            begin
                to_reg <= rd_stamp_reg;
                ao_reg <= rd_angle_reg;
            end
            OP_LOAD_OUT:
            begin
                out_angle_reg  <= (cmd.status == STATUS_OK) ? angle_reg : '0;
                out_stamp_reg  <= t_reg;
                out_status_reg <= cmd.status;
            end
            default:
            begin
            end
        endcase

        if (cmd.op == OP_MUL)
        begin
            ma_reg   <= mul_a[WIDE_W-1] ? WIDE_W'(-mul_a) : WIDE_W'(mul_a);
            mb_reg   <= mul_b[DIFF_W-1] ? DIFF_W'(-mul_b) : DIFF_W'(mul_b);
            mneg_reg <= mul_a[WIDE_W-1] ^ mul_b[DIFF_W-1];
            msub_reg <= mul_sub;
            prod_reg <= '0;
            mcnt_reg <= MCW'(DIFF_W);
        end
        else if (mbusy_reg)
        begin
            if (mcnt_reg != '0)
            begin
                prod_reg <= {prod_reg[PROD_W-2:0], 1'b0}
                          + (mb_reg[DIFF_W-1] ? PROD_W'(ma_reg) : '0);
                mb_reg   <= {mb_reg[DIFF_W-2:0], 1'b0};
                mcnt_reg <= mcnt_reg - MCW'(1);
            end
            else
            begin
                num_reg <= msub_reg ? num_reg - sprod : sprod;
            end
        end

        if (cmd.op == OP_DIV)
        begin
            dq_reg     <= num_mag;
            drem_reg   <= '0;
            dden_reg   <= div_den[DIFF_W-1] ? DIFF_W'(-div_den) : DIFF_W'(div_den);
            dneg_reg   <= num_reg[NUM_W-1] ^ div_den[DIFF_W-1];
            dsat32_reg <= (cmd.step == NV_FIN_DIV);
            ddest_reg  <= (cmd.step == NV_NM_DIV) ? 2'd0 :
                          (cmd.step == NV_MO_DIV) ? 2'd1 : 2'd2;
            dcnt_reg   <= DCW'(NUM_W);
        end
        else if (dbusy_reg)
        begin
            if (dcnt_reg != '0)
            begin
                drem_reg <= dfits ? DIFF_W'(dtrial)
                                  : {drem_reg[DIFF_W-2:0], dq_reg[NUM_W-1]};
                dq_reg   <= {dq_reg[NUM_W-2:0], dfits};
                dcnt_reg <= dcnt_reg - DCW'(1);
            end
            else
            begin
                unique case (ddest_reg)
                    2'd0:    pnm_reg   <= dres;
                    2'd1:    pmo_reg   <= dres;
                    default: angle_reg <= dres[ANGLE_W-1:0];
                endcase
            end
        end
    end

    assign stat.under3    = (count_reg < CW'(MIN_SAMPLES));
    assign stat.hit       = (rd_stamp_reg <= t_reg);
    assign stat.k_last    = k_last;
    assign stat.eq_stamps = (tn_reg == tm_reg) || (tm_reg == to_reg) || (tn_reg == to_reg);
    assign stat.mul_done  = mbusy_reg && (mcnt_reg == '0);
    assign stat.div_done  = dbusy_reg && (dcnt_reg == '0);

    assign out_angle  = out_angle_reg;
    assign out_stamp  = out_stamp_reg;
    assign out_status = out_status_reg;

endmodule
